// ===== src/lsr_pkg.sv =====
// Shared types and constants for the line segment rasterizer.
`timescale 1ns / 1ps

package lsr_pkg;

  localparam int CHUNK_W = 7;
  localparam int COLOR_W = 24;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture segment fields
    logic setup;      // axis choice, swap, span, minor delta
    logic div_start;  // launch chunk-offset division
    logic init;       // seed the walk at the chunk's first step
    logic emit;       // load one pixel into the output register and advance
  } lsr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;       // chunk starts past the segment's end
    logic div_busy;
    logic last_step;  // current step is the last one of this item
  } lsr_sts_t;

endpackage

// ===== src/lsr_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lsr_divider #(
  parameter int DW = 26,
  parameter int NW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient,
  output logic [NW-1:0] remainder
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo;
  logic [NW-1:0]   rem;
  logic [NW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic [NW:0]     shifted;
  logic [NW:0]     diff;
  logic            ge;

  assign shifted   = {rem, quo[DW-1]};
  assign ge        = shifted >= {1'b0, dvs};
  assign diff      = shifted - {1'b0, dvs};
  assign busy      = cnt != '0;
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNTW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[NW-1:0] : shifted[NW-1:0];
      quo <= {quo[DW-2:0], ge};
    end
  end

endmodule

// ===== src/lsr_datapath.sv =====
// Datapath: segment setup, chunk offset division and the incremental minor-axis walk.
`timescale 1ns / 1ps

module lsr_datapath #(
  parameter int COORD_BITS  = 12,
  parameter int CHUNK_STEPS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lsr_pkg::lsr_cmd_t            cmd,
  output lsr_pkg::lsr_sts_t            sts,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_height,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] end_height,
  input  logic [lsr_pkg::COLOR_W-1:0]  seg_color,
  input  logic [lsr_pkg::CHUNK_W-1:0]  chunk_index,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS:0]   pixel_y,
  output logic [lsr_pkg::COLOR_W-1:0]  pixel_color,
  output logic                         final_pixel
);

  localparam int CW   = COORD_BITS + 1;   // screen coordinate
  localparam int NW   = COORD_BITS + 1;   // span
  localparam int DMW  = COORD_BITS + 2;   // minor delta, |dmin| <= n
  localparam int DIFW = CW + 1;
  localparam int FW   = lsr_pkg::CHUNK_W + $clog2(CHUNK_STEPS);
  localparam int DW   = FW + NW;
  localparam int KW   = ((FW > NW) ? FW : NW) + 1;
  localparam int SW   = (CHUNK_STEPS > 1) ? $clog2(CHUNK_STEPS) : 1;
  localparam int QW   = COORD_BITS + 2;   // floor quotient, may dip one below minor

  // captured segment
  logic signed [CW-1:0]         x0_r, y0_r, x1_r, y1_r;
  logic [lsr_pkg::COLOR_W-1:0]  color_r;
  logic [lsr_pkg::CHUNK_W-1:0]  chunk_r;

  // setup results
  logic                 xm_r;
  logic signed [CW-1:0] m0_r, p0_r;
  logic [NW-1:0]        n_r;
  logic signed [DMW-1:0] dmin_r;
  logic [FW-1:0]        first_r;

  // walk state: minor = floor quotient q_r with remainder r_r over n
  logic signed [QW-1:0] q_r;
  logic [NW-1:0]        r_r;
  logic signed [CW-1:0] major_r;
  logic [KW-1:0]        k_r;
  logic [SW-1:0]        s_r;

  // setup logic
  logic signed [DIFW-1:0] dx, dy, dx_neg, dy_neg;
  logic [DIFW-1:0]        adx, ady;
  logic                   xm;
  logic signed [CW-1:0]   ma, mb, pa, pb, m0, m1, p0, p1;
  logic                   swap;

  always_comb begin
    dx     = DIFW'(x1_r) - DIFW'(x0_r);
    dy     = DIFW'(y1_r) - DIFW'(y0_r);
    dx_neg = -dx;
    dy_neg = -dy;
    adx    = dx[DIFW-1] ? dx_neg : dx;
    ady    = dy[DIFW-1] ? dy_neg : dy;
    xm     = adx > ady;
    ma     = xm ? x0_r : y0_r;
    mb     = xm ? x1_r : y1_r;
    pa     = xm ? y0_r : x0_r;
    pb     = xm ? y1_r : x1_r;
    swap   = ma > mb;
    m0     = swap ? mb : ma;
    m1     = swap ? ma : mb;
    p0     = swap ? pb : pa;
    p1     = swap ? pa : pb;
  end

  // chunk offset: first * |dmin|, divided by n
  logic signed [DMW-1:0] dmin_neg;
  logic [NW-1:0]         adm;
  logic [DW-1:0]         prod;
  logic [DW-1:0]         quo;
  logic [NW-1:0]         rem;
  logic                  div_busy;

  assign dmin_neg = -dmin_r;
  assign adm      = dmin_r[DMW-1] ? NW'(dmin_neg) : NW'(dmin_r);
  assign prod     = DW'(first_r) * DW'(adm);

  lsr_divider #(
    .DW(DW),
    .NW(NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (n_r),
    .busy     (div_busy),
    .quotient (quo),
    .remainder(rem)
  );

  // floor(first*dmin / n) from the unsigned magnitude result
  logic                  fzero;
  logic signed [DW:0]    quo_s, fq;
  logic [NW-1:0]         fr;
  logic signed [QW-1:0]  q_init;

  always_comb begin
    fzero = (first_r == '0) || (dmin_r == '0);
    quo_s = signed'((DW + 1)'(quo));
    if (fzero) begin
      fq = '0;
      fr = '0;
    end else if (!dmin_r[DMW-1]) begin
      fq = quo_s;
      fr = rem;
    end else if (rem == '0) begin
      fq = -quo_s;
      fr = '0;
    end else begin
      fq = -quo_s - (DW + 1)'(1);
      fr = n_r - rem;
    end
    q_init = QW'((DW + 1)'(p0_r) + fq);
  end

  // per-step increment: dmin = dq*n + dr, dq in {-1, 0, 1}
  logic signed [DMW-1:0] n_s;
  logic signed [2:0]     dq, qadd;
  logic [NW-1:0]         dr;
  logic [NW:0]           rsum;
  logic                  carry;
  logic [NW-1:0]         r_step;
  logic signed [QW-1:0]  q_step, minor;

  always_comb begin
    n_s = signed'(DMW'(n_r));
    if (dmin_r == n_s) begin
      dq = 3'sd1;
      dr = '0;
    end else if (!dmin_r[DMW-1]) begin
      dq = 3'sd0;
      dr = NW'(dmin_r);
    end else begin
      dq = -3'sd1;
      dr = NW'(dmin_r + n_s);
    end
    rsum   = (NW + 1)'(r_r) + (NW + 1)'(dr);
    carry  = rsum >= (NW + 1)'(n_r);
    qadd   = dq + (carry ? 3'sd1 : 3'sd0);
    r_step = carry ? NW'(rsum - (NW + 1)'(n_r)) : NW'(rsum);
    q_step = q_r + QW'(qadd);
    // truncate toward zero: a negative value with a remainder rounds up
    minor  = (q_r[QW-1] && (r_r != '0)) ? q_r + QW'(1) : q_r;
  end

  assign sts.skip      = KW'(first_r) > KW'(n_r);
  assign sts.div_busy  = div_busy;
  assign sts.last_step = (k_r == KW'(n_r)) || (s_r == SW'(CHUNK_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r    <= CW'(start_x);
      y0_r    <= CW'(start_y) - CW'(start_height);
      x1_r    <= CW'(end_x);
      y1_r    <= CW'(end_y) - CW'(end_height);
      color_r <= seg_color;
      chunk_r <= chunk_index;
    end
    if (cmd.setup) begin
      xm_r    <= xm;
      m0_r    <= m0;
      p0_r    <= p0;
      n_r     <= NW'(m1 - m0);
      dmin_r  <= DMW'(p1) - DMW'(p0);
      first_r <= FW'(chunk_r) * FW'(CHUNK_STEPS);
    end
    if (cmd.init) begin
      q_r     <= q_init;
      r_r     <= fr;
      major_r <= m0_r + CW'(first_r);
      k_r     <= KW'(first_r);
      s_r     <= '0;
    end else if (cmd.emit) begin
      q_r     <= q_step;
      r_r     <= r_step;
      major_r <= major_r + CW'(1);
      k_r     <= k_r + 1'b1;
      s_r     <= s_r + 1'b1;
    end
    if (cmd.emit) begin
      pixel_x     <= xm_r ? major_r[COORD_BITS-1:0] : minor[COORD_BITS-1:0];
      pixel_y     <= xm_r ? minor[CW-1:0] : major_r;
      pixel_color <= color_r;
      final_pixel <= k_r == KW'(n_r);
    end
  end

endmodule

// ===== src/lsr_ctrl.sv =====
// Controller: sequences setup, division and pixel emission; owns both handshakes.
`timescale 1ns / 1ps

module lsr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              seg_valid,
  output logic              seg_stall,
  output logic              pix_valid,
  input  logic              pix_stall,
  output lsr_pkg::lsr_cmd_t cmd,
  input  lsr_pkg::lsr_sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_INIT  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   pix_valid_next;
  logic   out_free;

  assign out_free  = !pix_valid || !pix_stall;
  assign seg_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (seg_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (sts.skip) begin
          state_next = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_step) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    pix_valid_next = cmd.emit || (pix_valid && pix_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pix_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pix_valid <= pix_valid_next;
    end
  end

endmodule

// ===== src/line_segment_rasterizer.sv =====
// Top level of the line segment rasterizer.
//
// Segment channel (seg_valid / seg_stall): one transfer carries two endpoints
// (x, y, height), a color and a chunk number. Screen y is y minus height.
// Pixel channel (pix_valid / pix_stall): the block walks the segment along its
// major axis and delivers the chunk's pixels one per transfer, in step order,
// with final_pixel set on the segment's last step.
// One segment is processed at a time; seg_stall stays high from the cycle after
// a transfer until the last pixel of that chunk sits in the output register.
// Setup, a multiply state and a restoring division seed the walk; then the block
// delivers one pixel per cycle while the receiver takes them. A chunk that starts
// past the segment's end produces no pixel and frees the input.
// When the receiver stalls, the pixel is held and the walk pauses.
// Reset (rst, synchronous) empties the output register and returns to idle.
`timescale 1ns / 1ps

module line_segment_rasterizer #(
  parameter int COORD_BITS  = 12,
  parameter int CHUNK_STEPS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         seg_valid,
  output logic                         seg_stall,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_height,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] end_height,
  input  logic [lsr_pkg::COLOR_W-1:0]  seg_color,
  input  logic [lsr_pkg::CHUNK_W-1:0]  chunk_index,
  output logic                         pix_valid,
  input  logic                         pix_stall,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS:0]   pixel_y,
  output logic [lsr_pkg::COLOR_W-1:0]  pixel_color,
  output logic                         final_pixel
);

  lsr_pkg::lsr_cmd_t cmd;
  lsr_pkg::lsr_sts_t sts;

  lsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .seg_valid(seg_valid),
    .seg_stall(seg_stall),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  lsr_datapath #(
    .COORD_BITS (COORD_BITS),
    .CHUNK_STEPS(CHUNK_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_height(start_height),
    .end_x       (end_x),
    .end_y       (end_y),
    .end_height  (end_height),
    .seg_color   (seg_color),
    .chunk_index (chunk_index),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .final_pixel (final_pixel)
  );

endmodule

// ===== src/lsr_checker.sv =====
// Port-level checks for the line segment rasterizer, bound to the top level.
`timescale 1ns / 1ps

module lsr_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         seg_valid,
  input logic                         seg_stall,
  input logic                         pix_valid,
  input logic                         pix_stall,
  input logic signed [COORD_BITS-1:0] pixel_x,
  input logic signed [COORD_BITS:0]   pixel_y,
  input logic [lsr_pkg::COLOR_W-1:0]  pixel_color,
  input logic                         final_pixel
);

  // reset leaves the block idle with an empty output register
  a_reset_idle: assert property (@(posedge clk) rst |=> !pix_valid && !seg_stall)
    else $error("block not idle after reset");

  // one segment at a time: a transfer closes the input
  a_one_segment: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_stall |=> seg_stall)
    else $error("segment input open right after a transfer");

  // setup takes several cycles before any pixel of the new segment appears
  a_no_early_pixel: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_stall |=> !$rose(pix_valid) ##1 !$rose(pix_valid))
    else $error("pixel appeared before setup finished");

  // a stalled pixel is held
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_color) && $stable(final_pixel))
    else $error("stalled pixel changed");

endmodule

bind line_segment_rasterizer lsr_checker #(
  .COORD_BITS(COORD_BITS)
) u_lsr_checker (
  .clk        (clk),
  .rst        (rst),
  .seg_valid  (seg_valid),
  .seg_stall  (seg_stall),
  .pix_valid  (pix_valid),
  .pix_stall  (pix_stall),
  .pixel_x    (pixel_x),
  .pixel_y    (pixel_y),
  .pixel_color(pixel_color),
  .final_pixel(final_pixel)
);

// ===== tb/tb.sv =====
// Self-checking testbench for line_segment_rasterizer: segment stimulus, pixel prediction, checks.
`timescale 1ns / 1ps

module tb;

  localparam int COORD_BITS  = 12;
  localparam int CHUNK_STEPS = 64;
  localparam int NUM_RANDOM  = 430;
  localparam int CALM_FROM   = 370;

  typedef struct {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_height;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_height;
    logic [lsr_pkg::COLOR_W-1:0]  color;
    logic [lsr_pkg::CHUNK_W-1:0]  chunk;
  } segment_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS:0]   y;
    logic [lsr_pkg::COLOR_W-1:0]  color;
    logic                         last;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t pending[$];
    int     errors;

    // Walk the chunk of the segment and queue the pixels it must produce.
    function void note_segment(segment_t s);
      longint x0, y0, x1, y1, adx, ady, m0, m1, p0, p1, tmp, span, dminor;
      longint k, k_stop, major, minor;
      bit     x_major;
      pixel_t p;
      x0 = s.start_x;
      x1 = s.end_x;
      y0 = longint'(s.start_y) - longint'(s.start_height);
      y1 = longint'(s.end_y) - longint'(s.end_height);
      adx = x1 - x0;
      if (adx < 0) adx = -adx;
      ady = y1 - y0;
      if (ady < 0) ady = -ady;
      x_major = adx > ady;
      if (x_major) begin
        m0 = x0; m1 = x1; p0 = y0; p1 = y1;
      end else begin
        m0 = y0; m1 = y1; p0 = x0; p1 = x1;
      end
      if (m0 > m1) begin
        tmp = m0; m0 = m1; m1 = tmp;
        tmp = p0; p0 = p1; p1 = tmp;
      end
      span = m1 - m0;
      dminor = p1 - p0;
      k = longint'(s.chunk) * CHUNK_STEPS;
      k_stop = k + CHUNK_STEPS - 1;
      if (k_stop > span) k_stop = span;
      while (k <= k_stop) begin
        // exact quotient, truncated toward zero as a whole
        minor = (span > 0) ? (p0 * span + k * dminor) / span : p0;
        major = m0 + k;
        if (x_major) begin
          p.x = major[COORD_BITS-1:0];
          p.y = minor[COORD_BITS:0];
        end else begin
          p.x = minor[COORD_BITS-1:0];
          p.y = major[COORD_BITS:0];
        end
        p.color = s.color;
        p.last = (k == span);
        pending.push_back(p);
        k++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel: x=%0d y=%0d color=%h last=%0b",
                   got.x, got.y, got.color, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: exp x=%0d y=%0d color=%h last=%0b, got x=%0d y=%0d color=%h last=%0b",
                   want.x, want.y, want.color, want.last,
                   got.x, got.y, got.color, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0;
  logic seg_stall;
  logic signed [COORD_BITS-1:0] start_x = '0;
  logic signed [COORD_BITS-1:0] start_y = '0;
  logic signed [COORD_BITS-1:0] start_height = '0;
  logic signed [COORD_BITS-1:0] end_x = '0;
  logic signed [COORD_BITS-1:0] end_y = '0;
  logic signed [COORD_BITS-1:0] end_height = '0;
  logic [lsr_pkg::COLOR_W-1:0] seg_color = '0;
  logic [lsr_pkg::CHUNK_W-1:0] chunk_index = '0;
  logic pix_valid;
  logic pix_stall = 1'b0;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic [lsr_pkg::COLOR_W-1:0] pixel_color;
  logic final_pixel;

  pixel_scoreboard board = new();

  bit calm = 1'b0;
  int src_pct = 0;
  int sink_pct = 0;
  int stall_left = 0;

  line_segment_rasterizer #(
    .COORD_BITS (COORD_BITS),
    .CHUNK_STEPS(CHUNK_STEPS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .seg_valid   (seg_valid),
    .seg_stall   (seg_stall),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_height(start_height),
    .end_x       (end_x),
    .end_y       (end_y),
    .end_height  (end_height),
    .seg_color   (seg_color),
    .chunk_index (chunk_index),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .final_pixel (final_pixel)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (calm) begin
      pix_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      pix_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (int'($urandom_range(0, 99)) < sink_pct) begin
      pix_stall <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      pix_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    if (!rst && pix_valid && !pix_stall) begin
      got.x = pixel_x;
      got.y = pixel_y;
      got.color = pixel_color;
      got.last = final_pixel;
      board.check_pixel(got);
    end
  end

  function automatic segment_t make_segment(int sx, int sy, int sh, int ex, int ey, int eh,
                                            int unsigned color, int chunk);
    segment_t s;
    s.start_x = sx[COORD_BITS-1:0];
    s.start_y = sy[COORD_BITS-1:0];
    s.start_height = sh[COORD_BITS-1:0];
    s.end_x = ex[COORD_BITS-1:0];
    s.end_y = ey[COORD_BITS-1:0];
    s.end_height = eh[COORD_BITS-1:0];
    s.color = color[lsr_pkg::COLOR_W-1:0];
    s.chunk = chunk[lsr_pkg::CHUNK_W-1:0];
    return s;
  endfunction

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Mostly well-formed chunks that land inside the segment; some past its end.
  function automatic segment_t random_segment();
    int sx, sy, sh, ex, ey, eh, kind, dx, dy, span, chunk;
    kind = $urandom_range(0, 9);
    if (kind <= 3 || kind == 8) begin
      sx = rand_in(-2048, 2047); sy = rand_in(-2048, 2047); sh = rand_in(-2048, 2047);
      ex = rand_in(-2048, 2047); ey = rand_in(-2048, 2047); eh = rand_in(-2048, 2047);
    end else if (kind == 7) begin
      sx = rand_in(-1000, 1000); sy = rand_in(-1000, 1000); sh = rand_in(-1000, 1000);
      ex = sx; ey = sy; eh = sh;
      case ($urandom_range(0, 3))
        0: ;
        1: ex = sx + rand_in(-900, 900);
        2: ey = sy + rand_in(-900, 900);
        default: begin
          dx = rand_in(-900, 900);
          ex = sx + dx;
          ey = sy + (($urandom_range(0, 1) == 1) ? dx : -dx);
        end
      endcase
    end else begin
      sx = rand_in(-1900, 1900); sy = rand_in(-1900, 1900); sh = rand_in(-1900, 1900);
      ex = sx + rand_in(-40, 40); ey = sy + rand_in(-40, 40); eh = sh + rand_in(-20, 20);
    end
    dx = ex - sx;
    if (dx < 0) dx = -dx;
    dy = (ey - eh) - (sy - sh);
    if (dy < 0) dy = -dy;
    span = (dx > dy) ? dx : dy;
    if (kind == 8)
      chunk = $urandom_range(0, 127);
    else if (kind == 9)
      chunk = rand_in(1, 127);
    else
      chunk = rand_in(0, span / CHUNK_STEPS);
    return make_segment(sx, sy, sh, ex, ey, eh, $urandom, chunk);
  endfunction

  task automatic send_segment(segment_t s);
    seg_valid <= 1'b1;
    start_x <= s.start_x;
    start_y <= s.start_y;
    start_height <= s.start_height;
    end_x <= s.end_x;
    end_y <= s.end_y;
    end_height <= s.end_height;
    seg_color <= s.color;
    chunk_index <= s.chunk;
    do @(posedge clk); while (seg_stall);
    board.note_segment(s);
  endtask

  task automatic maybe_idle();
    if (!calm && int'($urandom_range(0, 99)) < src_pct) begin
      seg_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    send_segment(make_segment(0, 0, 0, 0, 0, 0, 24'h000000, 0));
    send_segment(make_segment(5, -7, 3, 5, -7, 3, 24'hFFFFFF, 0));
    send_segment(make_segment(5, 5, 0, 5, 5, 0, 24'h123456, 1));
    send_segment(make_segment(-2048, -2048, -2048, -2048, -2048, -2048, 24'hA5A5A5, 0));
    send_segment(make_segment(2047, 2047, 2047, 2047, 2047, 2047, 24'h5A5A5A, 0));
    send_segment(make_segment(-2048, 0, 0, 2047, 0, 0, 24'hFF0000, 0));
    send_segment(make_segment(-2048, 0, 0, 2047, 0, 0, 24'h00FF00, 63));
    send_segment(make_segment(2047, 10, 0, -2048, -10, 0, 24'h0000FF, 31));
    // longest screen span: y from -4095 to 4095
    send_segment(make_segment(0, -2048, 2047, 0, 2047, -2048, 24'hFFFFFF, 127));
    send_segment(make_segment(-2048, -2048, 2047, 2047, 2047, -2048, 24'h000000, 0));
    send_segment(make_segment(-2048, -2048, 2047, 2047, 2047, -2048, 24'h808080, 64));
    send_segment(make_segment(0, 0, 0, 20, 20, 0, 24'h111111, 0));
    send_segment(make_segment(20, 0, 0, 0, -20, 0, 24'h222222, 0));
    send_segment(make_segment(0, 0, 0, 37, -11, 0, 24'h333333, 0));
    send_segment(make_segment(3, 0, 0, -30, 7, 0, 24'h444444, 0));
    send_segment(make_segment(-5, 0, 10, 8, 0, -50, 24'h555555, 0));
    send_segment(make_segment(0, 0, 0, 10, 3, 0, 24'h666666, 1));
    send_segment(make_segment(0, 0, 0, 63, 0, 0, 24'h777777, 0));
    send_segment(make_segment(0, 0, 0, 64, 0, 0, 24'h888888, 1));
    send_segment(make_segment(0, 0, 0, 64, 0, 0, 24'h999999, 127));
    send_segment(make_segment(-1, 1, -1, 1, -1, 1, 24'hABCDEF, 0));
    send_segment(make_segment(-7, -3, 0, 9, 40, 25, 24'hFEDCBA, 0));
  endtask

  initial begin
    int idx;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (idx = 0; idx < NUM_RANDOM; idx++) begin
      if (idx % 60 == 0) begin
        src_pct = 15 * $urandom_range(0, 3);
        sink_pct = 10 * $urandom_range(0, 4);
      end
      if (idx == CALM_FROM) calm = 1'b1;
      if (idx == 200) begin
        // drain the pixel channel completely before going on
        seg_valid <= 1'b0;
        do @(posedge clk); while (board.pending.size() != 0);
      end
      maybe_idle();
      send_segment(random_segment());
    end
    seg_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
